// ===== rtl/fcp_pkg.sv =====
package fcp_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int FILL_W      = $clog2(FRAME_DEPTH);
  localparam int BANK_DEPTH  = 1 << FILL_W;
  localparam int STORE_DEPTH = 2 * BANK_DEPTH;
  localparam int STORE_AW    = FILL_W + 1;

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;

  localparam int ECHO_PREFIX_LEN = 6;
  localparam int NUM_EXACT       = 7;
  localparam int CMD_MAX         = 18;
  localparam int CHAR_W          = 5;

  typedef enum logic [3:0] {
    CODE_PING      = 4'd0,
    CODE_RST_STATS = 4'd1,
    CODE_TLM_START = 4'd2,
    CODE_TLM_STOP  = 4'd3,
    CODE_DBG_ON    = 4'd4,
    CODE_DBG_OFF   = 4'd5,
    CODE_BUZZER    = 4'd6,
    CODE_ECHO      = 4'd7,
    CODE_UNKNOWN   = 4'd8
  } cmd_code_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HOLD,
    BK_READ
  } back_state_t;

  typedef struct packed {
    cmd_code_t         code;
    logic              bank;
    logic [FILL_W-1:0] plen;
  } cmd_desc_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
  } store_rd_t;

  // Command texts, left aligned and zero padded
  localparam logic [8*CMD_MAX-1:0] TXT_PING  = {"<PING>", {(CMD_MAX-6){8'h00}}};
  localparam logic [8*CMD_MAX-1:0] TXT_RSTAT = {"<RESET_", "STATS>", {(CMD_MAX-13){8'h00}}};
  localparam logic [8*CMD_MAX-1:0] TXT_TSTRT = {"<START_", "TELEMETRY>",
                                                {(CMD_MAX-17){8'h00}}};
  localparam logic [8*CMD_MAX-1:0] TXT_TSTOP = {"<STOP_", "TELEMETRY>",
                                                {(CMD_MAX-16){8'h00}}};
  localparam logic [8*CMD_MAX-1:0] TXT_DBGON = {"<USB_DEBUG_", "ON>", {(CMD_MAX-14){8'h00}}};
  localparam logic [8*CMD_MAX-1:0] TXT_DBGOF = {"<USB_DEBUG_", "OFF>", {(CMD_MAX-15){8'h00}}};
  localparam logic [8*CMD_MAX-1:0] TXT_BUZZ  = {"<ECHO:BUZZER_", "TEST>"};

  // Position of the closing '>' in each exact command
  function automatic logic [CHAR_W-1:0] cmd_close_pos(input cmd_code_t k);
    logic [CHAR_W-1:0] pos;
    unique case (k)
      CODE_PING:      pos = 5'd5;
      CODE_RST_STATS: pos = 5'd12;
      CODE_TLM_START: pos = 5'd16;
      CODE_TLM_STOP:  pos = 5'd15;
      CODE_DBG_ON:    pos = 5'd13;
      CODE_DBG_OFF:   pos = 5'd14;
      CODE_BUZZER:    pos = 5'd17;
      default:        pos = '1;
    endcase
    return pos;
  endfunction

  // The buzzer text also carries the echo prefix in its first six characters
  function automatic logic [7:0] cmd_char(input cmd_code_t k, input logic [CHAR_W-1:0] i);
    logic [8*CMD_MAX-1:0] txt;
    logic [7:0]           ch;
    unique case (k)
      CODE_PING:      txt = TXT_PING;
      CODE_RST_STATS: txt = TXT_RSTAT;
      CODE_TLM_START: txt = TXT_TSTRT;
      CODE_TLM_STOP:  txt = TXT_TSTOP;
      CODE_DBG_ON:    txt = TXT_DBGON;
      CODE_DBG_OFF:   txt = TXT_DBGOF;
      CODE_BUZZER:    txt = TXT_BUZZ;
      default:        txt = '0;
    endcase
    if (int'(i) < CMD_MAX) begin
      ch = txt[8*(CMD_MAX-1-int'(i)) +: 8];
    end else begin
      ch = 8'h00;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/fcp_ram.sv =====
module fcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fcp_front.sv =====
module fcp_front import fcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output store_wr_t  wr,
  output logic       push,
  output cmd_desc_t  push_desc,
  input  logic       frame_done
);

  logic                 in_frame_r, in_frame_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [NUM_EXACT-1:0] match_r, match_nxt;
  logic                 echo_r, echo_nxt;
  logic                 bank_r, bank_nxt;
  logic [1:0]           pend_r, pend_nxt;

  logic                 accept;
  logic                 is_open;
  logic                 is_close;
  logic                 full;
  logic                 store;
  logic                 close;
  logic [NUM_EXACT-1:0] hit;
  logic                 echo_hit;
  cmd_code_t            code_sel;
  logic [FILL_W-1:0]    plen;

  // Two frames in flight fill both banks of the frame store
  assign in_stall = (pend_r == 2'd2);
  assign accept   = in_valid & ~in_stall;
  assign is_open  = (in_rx_byte == CH_OPEN);
  assign is_close = (in_rx_byte == CH_CLOSE);
  assign full     = (fill_r >= FILL_W'(FRAME_DEPTH - 1));
  assign store    = accept & in_frame_r & ~is_open & ~is_close & ~full;
  assign close    = accept & in_frame_r & is_close;

  always_comb begin
    for (int k = 0; k < NUM_EXACT; k++) begin
      hit[k] = (fill_r < FILL_W'(cmd_close_pos(cmd_code_t'(k)))) &&
               (in_rx_byte == cmd_char(cmd_code_t'(k), fill_r[CHAR_W-1:0]));
    end
    echo_hit = (fill_r >= FILL_W'(ECHO_PREFIX_LEN)) ||
               (in_rx_byte == cmd_char(CODE_BUZZER, fill_r[CHAR_W-1:0]));
  end

  // Lowest command index wins; echo only when no exact command fits
  always_comb begin
    code_sel = CODE_UNKNOWN;
    plen     = '0;
    if (echo_r && fill_r >= FILL_W'(ECHO_PREFIX_LEN)) begin
      code_sel = CODE_ECHO;
      plen     = fill_r - FILL_W'(ECHO_PREFIX_LEN);
    end
    for (int k = NUM_EXACT - 1; k >= 0; k--) begin
      if (match_r[k] && fill_r == FILL_W'(cmd_close_pos(cmd_code_t'(k)))) begin
        code_sel = cmd_code_t'(k);
      end
    end
  end

  assign wr.en          = store;
  assign wr.addr        = {bank_r, fill_r};
  assign wr.data        = in_rx_byte;
  assign push           = close;
  assign push_desc.code = code_sel;
  assign push_desc.bank = bank_r;
  assign push_desc.plen = (code_sel == CODE_ECHO) ? plen : '0;

  always_comb begin
    in_frame_nxt = in_frame_r;
    fill_nxt     = fill_r;
    match_nxt    = match_r;
    echo_nxt     = echo_r;
    bank_nxt     = bank_r;
    if (accept) begin
      priority if (is_open) begin
        in_frame_nxt = 1'b1;
        fill_nxt     = FILL_W'(1);
        match_nxt    = '1;
        echo_nxt     = 1'b1;
      end else if (!in_frame_r) begin
        in_frame_nxt = 1'b0;
      end else if (is_close) begin
        in_frame_nxt = 1'b0;
        fill_nxt     = '0;
        bank_nxt     = ~bank_r;
      end else if (full) begin
        // drop the frame silently
        in_frame_nxt = 1'b0;
        fill_nxt     = '0;
      end else begin
        fill_nxt  = fill_r + FILL_W'(1);
        match_nxt = match_r & hit;
        echo_nxt  = echo_r & echo_hit;
      end
    end
  end

  always_comb begin
    unique case ({push, frame_done})
      2'b10:   pend_nxt = pend_r + 2'd1;
      2'b01:   pend_nxt = pend_r - 2'd1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      fill_r     <= '0;
      match_r    <= '0;
      echo_r     <= 1'b0;
      bank_r     <= 1'b0;
      pend_r     <= 2'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      fill_r     <= fill_nxt;
      match_r    <= match_nxt;
      echo_r     <= echo_nxt;
      bank_r     <= bank_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

// ===== rtl/fcp_queue.sv =====
module fcp_queue import fcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_desc_t push_desc,
  input  logic      pop,
  output cmd_desc_t pop_desc,
  output logic      not_empty
);

  cmd_desc_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 2'd0);
  assign pop_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/fcp_back.sv =====
module fcp_back import fcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_desc_t  q_desc,
  output logic       pop,
  output store_rd_t  rd,
  input  logic [7:0] rd_data,
  output logic       frame_done,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_command_code,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_byte,
  output logic       out_last,
  output logic       out_telemetry_on,
  output logic       out_debug_on
);

  back_state_t       state_r, state_nxt;
  cmd_desc_t         desc_r, desc_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic              tel_r, tel_nxt;
  logic              dbg_r, dbg_nxt;
  cmd_code_t         code_r, code_nxt;
  logic              ev_r, ev_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              otel_r, otel_nxt;
  logic              odbg_r, odbg_nxt;

  logic              taken;
  logic              load_byte;
  logic [FILL_W-1:0] rd_idx;

  assign taken  = out_valid & ~out_stall;
  assign rd_idx = FILL_W'(ECHO_PREFIX_LEN) + idx_r;

  always_comb begin
    unique case (state_r)
      BK_IDLE: state_nxt = q_valid ? BK_HOLD : BK_IDLE;
      BK_HOLD: begin
        if (taken) begin
          state_nxt = last_r ? BK_IDLE : BK_READ;
        end else begin
          state_nxt = BK_HOLD;
        end
      end
      BK_READ: state_nxt = BK_HOLD;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid  = (state_r == BK_HOLD);
    pop        = (state_r == BK_IDLE) && q_valid;
    load_byte  = (state_r == BK_READ);
    rd.en      = (state_r == BK_HOLD) && taken && !last_r;
    rd.addr    = {desc_r.bank, rd_idx};
    frame_done = (state_r == BK_HOLD) && taken && last_r;
  end

  always_comb begin
    desc_nxt = desc_r;
    idx_nxt  = idx_r;
    tel_nxt  = tel_r;
    dbg_nxt  = dbg_r;
    code_nxt = code_r;
    ev_nxt   = ev_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    otel_nxt = otel_r;
    odbg_nxt = odbg_r;
    if (pop) begin
      unique case (q_desc.code)
        CODE_TLM_START: tel_nxt = 1'b1;
        CODE_TLM_STOP:  tel_nxt = 1'b0;
        CODE_DBG_ON:    dbg_nxt = 1'b1;
        CODE_DBG_OFF:   dbg_nxt = 1'b0;
        default:        tel_nxt = tel_r;
      endcase
      desc_nxt = q_desc;
      idx_nxt  = '0;
      code_nxt = q_desc.code;
      ev_nxt   = 1'b0;
      byte_nxt = 8'h00;
      last_nxt = (q_desc.code != CODE_ECHO) || (q_desc.plen == '0);
      otel_nxt = tel_nxt;
      odbg_nxt = dbg_nxt;
    end else if (load_byte) begin
      ev_nxt   = 1'b1;
      byte_nxt = rd_data;
      last_nxt = (idx_r == desc_r.plen - FILL_W'(1));
      idx_nxt  = idx_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    idx_r  <= idx_nxt;
    code_r <= code_nxt;
    ev_r   <= ev_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    otel_r <= otel_nxt;
    odbg_r <= odbg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      tel_r   <= 1'b0;
      dbg_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      tel_r   <= tel_nxt;
      dbg_r   <= dbg_nxt;
    end
  end

  assign out_command_code = code_r;
  assign out_echo_valid   = ev_r;
  assign out_echo_byte    = byte_r;
  assign out_last         = last_r;
  assign out_telemetry_on = otel_r;
  assign out_debug_on     = odbg_r;

endmodule

// ===== rtl/framed_command_parser.sv =====
// Channel  Handshake             Payload
// in       in_valid, in_stall    in_rx_byte
// out      out_valid, out_stall  out_command_code, out_echo_valid, out_echo_byte,
//                                out_last, out_telemetry_on, out_debug_on
//
// The front takes one byte per cycle while not stalled and classifies the frame
// while it is received. A closed frame's code result passes through the descriptor
// queue and then the back's output registers. Each echo payload byte goes through a
// frame store read and then the output register; the back idles between frames.
// The front stalls only while two closed frames are not yet finished by the back.
// Reset is synchronous, active low; the frame store is not cleared.
module framed_command_parser import fcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_command_code,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_byte,
  output logic       out_last,
  output logic       out_telemetry_on,
  output logic       out_debug_on
);

  store_wr_t  wr;
  store_rd_t  rd;
  logic [7:0] rd_data;
  logic       push;
  cmd_desc_t  push_desc;
  logic       pop;
  cmd_desc_t  pop_desc;
  logic       q_valid;
  logic       frame_done;

  fcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .wr         (wr),
    .push       (push),
    .push_desc  (push_desc),
    .frame_done (frame_done)
  );

  fcp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (rd_data)
  );

  fcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .not_empty (q_valid)
  );

  fcp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_desc           (pop_desc),
    .pop              (pop),
    .rd               (rd),
    .rd_data          (rd_data),
    .frame_done       (frame_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command_code (out_command_code),
    .out_echo_valid   (out_echo_valid),
    .out_echo_byte    (out_echo_byte),
    .out_last         (out_last),
    .out_telemetry_on (out_telemetry_on),
    .out_debug_on     (out_debug_on)
  );

endmodule

// ===== rtl/fcp_checker.sv =====
module fcp_checker import fcp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_command_code,
  input logic       out_echo_valid,
  input logic [7:0] out_echo_byte,
  input logic       out_last,
  input logic       out_telemetry_on,
  input logic       out_debug_on
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_command_code, out_echo_valid, out_echo_byte, out_last,
               out_telemetry_on, out_debug_on}))
    else $error("result changed while stalled");

  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_code != CODE_ECHO |-> out_last && !out_echo_valid)
    else $error("non-echo result must be a lone last result");

  a_echo_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_valid |-> out_command_code == CODE_ECHO)
    else $error("payload byte outside an echo frame");

  a_tlm_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_code == CODE_TLM_START ||
                  out_command_code == CODE_TLM_STOP) |->
      out_telemetry_on == (out_command_code == CODE_TLM_START))
    else $error("telemetry flag disagrees with command");

  a_dbg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_code == CODE_DBG_ON ||
                  out_command_code == CODE_DBG_OFF) |->
      out_debug_on == (out_command_code == CODE_DBG_ON))
    else $error("debug flag disagrees with command");

endmodule

bind framed_command_parser fcp_checker u_fcp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_command_code (out_command_code),
  .out_echo_valid   (out_echo_valid),
  .out_echo_byte    (out_echo_byte),
  .out_last         (out_last),
  .out_telemetry_on (out_telemetry_on),
  .out_debug_on     (out_debug_on)
);

// ===== verif/framed_command_parser_checker.sv =====
`timescale 1ns / 100ps

module framed_command_parser_checker import fcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_command_code,
  input  logic       out_echo_valid,
  input  logic [7:0] out_echo_byte,
  input  logic       out_last,
  input  logic       out_telemetry_on,
  input  logic       out_debug_on,
  output int         fail_count,
  output int         pending
);

  typedef struct {
    cmd_code_t   code;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        last;
    logic        telemetry;
    logic        debug;
  } cmd_result_t;

  localparam string ECHO_PREFIX = "<ECHO:";

  logic [7:0]  frame_buf [FRAME_DEPTH];
  int          fill;
  logic        collecting;
  logic        telemetry;
  logic        debug;
  int          mismatches;
  cmd_result_t expected_results [$];
  cmd_result_t head;

  function automatic string command_text(cmd_code_t c);
    case (c)
      CODE_PING:      return "<PING>";
      CODE_RST_STATS: return {"<RESET_", "STATS>"};
      CODE_TLM_START: return {"<START_", "TELEMETRY>"};
      CODE_TLM_STOP:  return {"<STOP_", "TELEMETRY>"};
      CODE_DBG_ON:    return {"<USB_DEBUG_", "ON>"};
      CODE_DBG_OFF:   return {"<USB_DEBUG_", "OFF>"};
      CODE_BUZZER:    return {"<ECHO:BUZZER_", "TEST>"};
      default:        return "";
    endcase
  endfunction

  function automatic logic frame_starts_with(string s);
    for (int i = 0; i < s.len(); i++) begin
      if (frame_buf[i] !== s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_result(cmd_code_t code, logic ev, logic [7:0] eb, logic last);
    cmd_result_t r;
    r = '{code, ev, eb, last, telemetry, debug};
    expected_results.push_back(r);
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    int        total;
    int        plen;
    cmd_code_t code;
    cmd_code_t c;
    string     txt;
    if (b == CH_OPEN) begin
      frame_buf[0] = b;
      fill = 1;
      collecting = 1'b1;
      return;
    end
    if (!collecting) return;
    if (b != CH_CLOSE) begin
      if (fill < FRAME_DEPTH - 1) begin
        frame_buf[fill] = b;
        fill++;
      end else begin
        // overlong frame: drop it without a word
        collecting = 1'b0;
        fill = 0;
      end
      return;
    end
    frame_buf[fill] = b;
    total = fill + 1;
    collecting = 1'b0;
    fill = 0;

    code = CODE_UNKNOWN;
    for (c = CODE_PING; c != CODE_ECHO; c = c.next()) begin
      txt = command_text(c);
      if (code == CODE_UNKNOWN && total == txt.len() && frame_starts_with(txt)) begin
        code = c;
      end
    end
    case (code)
      CODE_TLM_START: telemetry = 1'b1;
      CODE_TLM_STOP:  telemetry = 1'b0;
      CODE_DBG_ON:    debug = 1'b1;
      CODE_DBG_OFF:   debug = 1'b0;
      default: ;
    endcase

    if (code == CODE_UNKNOWN && total > ECHO_PREFIX_LEN && frame_starts_with(ECHO_PREFIX)) begin
      plen = total - 1 - ECHO_PREFIX_LEN;
      push_result(CODE_ECHO, 1'b0, 8'h00, plen == 0);
      for (int i = 0; i < plen; i++) begin
        push_result(CODE_ECHO, 1'b1, frame_buf[ECHO_PREFIX_LEN + i], i + 1 == plen);
      end
    end else begin
      push_result(code, 1'b0, 8'h00, 1'b1);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      collecting = 1'b0;
      telemetry = 1'b0;
      debug = 1'b1;
      mismatches = 0;
      expected_results.delete();
    end else begin
      // compare first, so a request taken at this edge cannot pair with its own result
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing, got code %0h byte %0h",
                   $time, out_command_code, out_echo_byte);
        end else begin
          head = expected_results.pop_front();
          check_field("command_code", head.code, out_command_code);
          check_field("echo_valid", head.echo_valid, out_echo_valid);
          check_field("echo_byte", head.echo_byte, out_echo_byte);
          check_field("last", head.last, out_last);
          check_field("telemetry_on", head.telemetry, out_telemetry_on);
          check_field("debug_on", head.debug, out_debug_on);
        end
      end
      if (in_valid && !in_stall) begin
        predict_byte(in_rx_byte);
      end
    end
    fail_count <= mismatches;
    pending    <= expected_results.size();
  end

endmodule

// ===== verif/framed_command_parser_tb.sv =====
`timescale 1ns / 100ps

module framed_command_parser_tb import fcp_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  typedef enum int {
    RX_RANDOM,
    RX_FREE,
    RX_HOLD
  } rx_mode_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [3:0] out_command_code;
  logic       out_echo_valid;
  logic [7:0] out_echo_byte;
  logic       out_last;
  logic       out_telemetry_on;
  logic       out_debug_on;

  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  int       bytes_sent  = 0;
  bit       tx_gapless  = 1'b0;
  rx_mode_t rx_mode     = RX_RANDOM;
  logic     hold_active = 1'b0;
  logic     hold_done   = 1'b0;

  framed_command_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command_code (out_command_code),
    .out_echo_valid   (out_echo_valid),
    .out_echo_byte    (out_echo_byte),
    .out_last         (out_last),
    .out_telemetry_on (out_telemetry_on),
    .out_debug_on     (out_debug_on)
  );

  framed_command_parser_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command_code (out_command_code),
    .out_echo_valid   (out_echo_valid),
    .out_echo_byte    (out_echo_byte),
    .out_last         (out_last),
    .out_telemetry_on (out_telemetry_on),
    .out_debug_on     (out_debug_on),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // any byte except the frame delimiters
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    if (b == CH_OPEN || b == CH_CLOSE) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic string cmd_text(int k);
    case (k)
      0:       return "<PING>";
      1:       return {"<RESET_", "STATS>"};
      2:       return {"<START_", "TELEMETRY>"};
      3:       return {"<STOP_", "TELEMETRY>"};
      4:       return {"<USB_DEBUG_", "ON>"};
      5:       return {"<USB_DEBUG_", "OFF>"};
      default: return {"<ECHO:BUZZER_", "TEST>"};
    endcase
  endfunction

  // valid stays high after acceptance; callers that wait must lower it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gapless ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side: random stalls, free-running stretches and one long hold-off
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (rx_mode == RX_HOLD && !hold_done) begin
        out_stall   <= 1'b1;
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall   <= 1'b0;
        hold_active <= 1'b0;
        hold_done   <= 1'b1;
        @(posedge clk);
      end else begin
        gap = (rx_mode == RX_FREE) ? 0 : pick_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    int         seq;
    int         kind;
    int         len;
    int         pos;
    string      text;
    logic [7:0] b;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("<PING>");
    send_text("<ECHO:Hi>");
    send_text("<ECHO:>");
    send_text("x>");
    // zero byte takes part in matching
    send_text("<PI");
    send_byte(8'h00);
    send_text("NG>");
    send_text("<ECHO:BUZZ<PING>");
    drain_results();

    // hold the result side off and keep offering frames until the input stalls
    rx_mode <= RX_HOLD;
    do @(posedge clk); while (!hold_active);
    tx_gapless = 1'b1;
    send_text("<ECHO:");
    repeat (FRAME_DEPTH - 7) send_byte(payload_byte());
    send_byte(CH_CLOSE);
    send_text(cmd_text(0));
    send_text(cmd_text(5));
    in_valid <= 1'b0;
    do @(posedge clk); while (!hold_done);
    rx_mode    <= RX_RANDOM;
    tx_gapless = 1'b0;
    drain_results();

    // one byte too many drops the frame; the close after it is ignored
    send_text("<ECHO:");
    repeat (FRAME_DEPTH - 6) send_byte(payload_byte());
    send_byte(CH_CLOSE);

    for (seq = 0; bytes_sent < 215; seq++) begin
      if (seq == 1) begin
        rx_mode    <= RX_FREE;
        tx_gapless = 1'b1;
      end
      if (seq == 3) begin
        rx_mode    <= RX_RANDOM;
        tx_gapless = 1'b0;
      end

      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send_text(cmd_text($urandom_range(0, 6)));
      end else if (kind < 60) begin
        send_text("<ECHO:");
        len = $urandom_range(0, 12);
        repeat (len) send_byte(payload_byte());
        send_byte(CH_CLOSE);
      end else if (kind < 80) begin
        // near miss: one character changed, or cut short
        text = cmd_text($urandom_range(0, 6));
        pos  = $urandom_range(1, text.len() - 2);
        if ($urandom_range(0, 1)) begin
          text[pos] = $urandom_range(8'h40, 8'h7E);
        end else begin
          text = {text.substr(0, pos - 1), ">"};
        end
        send_text(text);
      end else if (kind < 92) begin
        send_byte(CH_OPEN);
        len = $urandom_range(0, 10);
        repeat (len) begin
          if ($urandom_range(0, 15) == 0) begin
            b = $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE;
          end else begin
            b = $urandom_range(0, 255);
          end
          send_byte(b);
        end
        send_byte(CH_CLOSE);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          b = $urandom_range(0, 255);
          if (b == CH_OPEN) b = CH_CLOSE;
          send_byte(b);
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
